// ===== design/fractal_value_noise_top_assert.svh =====
// Assertion macros shared by the fractal value noise RTL.
`ifndef FRACTAL_VALUE_NOISE_TOP_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FVN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FVN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fvn_pkg.sv =====
// Package with the types, constants and helper functions of the value noise pipeline.
`default_nettype none
package fvn_pkg;
	localparam int GRID_SIZE = 1024;
	localparam int COORD_W = 10;
	localparam int OCTAVES = 6;
	localparam int PIPE_DEPTH = 8;
	localparam int POS_W = 35;
	localparam logic [24:0] FREQ_Q32 = 25'd21474836;
	localparam logic [31:0] OCT_SEED_STEP = 32'd1000;
	localparam logic [31:0] SEED_MUL = 32'd131;
	localparam logic [31:0] ROW_MUL = 32'd57;
	localparam logic [31:0] HASH_MUL = 32'd15731;
	localparam logic [31:0] HASH_ADD1 = 32'd789221;
	localparam logic [31:0] HASH_ADD2 = 32'd1376312589;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [17:0] height_t;
	typedef logic signed [17:0] noise_t;
	typedef logic [POS_W-1:0] pos_t;

	function automatic coord_t clamp_coord(input coord_t c);
		if (COORD_W'(c) > COORD_W'(GRID_SIZE - 1)) begin
			return COORD_W'(GRID_SIZE - 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] hash_pre(input logic [31:0] i, input logic [31:0] k,
			input logic [31:0] sb);
		logic [31:0] n;
		n = i + k * ROW_MUL + sb;
		return (n << 13) ^ n;
	endfunction
endpackage
`default_nettype wire

// ===== design/fvn_sample_if.sv =====
// Request channel that carries one sample coordinate pair.
`default_nettype none
interface fvn_sample_if;
	import fvn_pkg::*;
	logic valid;
	logic ready;
	coord_t x_coord;
	coord_t z_coord;
	modport source (output valid, output x_coord, output z_coord, input ready);
	modport sink (input valid, input x_coord, input z_coord, output ready);
endinterface
`default_nettype wire

// ===== design/fvn_result_if.sv =====
// Result channel that carries one terrain height.
`default_nettype none
interface fvn_result_if;
	import fvn_pkg::*;
	logic valid;
	logic ready;
	height_t height;
	modport source (output valid, output height, input ready);
	modport sink (input valid, input height, output ready);
endinterface
`default_nettype wire

// ===== design/fvn_hash.sv =====
// Three-stage lattice hash that maps a premixed lattice word to a Q1.16 value.
`default_nettype none
module fvn_hash (
	input wire logic clk,
	input wire logic en,
	input wire logic [31:0] n,
	output fvn_pkg::noise_t v
);
	import fvn_pkg::*;

	logic [31:0] n_s3, nn_s3, n_s4, t_s4, h;
	noise_t v_s5;

	assign h = (n_s4 * t_s4 + HASH_ADD2) & 32'h7fffffff;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= n;
			nn_s3 <= n * n;
			n_s4 <= n_s3;
			t_s4 <= nn_s3 * HASH_MUL + HASH_ADD1;
			v_s5 <= 18'sd65536 - $signed({1'b0, h[30:14]});
		end
	end

	assign v = v_s5;
endmodule
`default_nettype wire

// ===== design/fvn_octave.sv =====
// One octave of value noise: lattice cells, smoothstep weights, hashing and bilinear blend.
`default_nettype none
module fvn_octave (
	input wire logic clk,
	input wire logic en,
	input wire logic [2:0] oct,
	input wire fvn_pkg::pos_t px,
	input wire fvn_pkg::pos_t pz,
	input wire logic [31:0] sbase,
	output fvn_pkg::noise_t noise
);
	import fvn_pkg::*;

	logic [39:0] sx_pos, sz_pos;
	logic [31:0] ix, iz;
	logic [31:0] n_s2 [4];
	logic [15:0] fx_s2, fz_s2;
	logic [31:0] ffx_s2, ffz_s2;
	logic [49:0] smx, smz;
	logic [15:0] sx_s3, sz_s3;
	logic [16:0] rx, rz, sx_w, sz_w;
	logic [33:0] w_s4 [4];
	logic [33:0] w_s5 [4];
	noise_t v [4];
	logic signed [52:0] p_s6 [4];
	logic signed [54:0] acc;
	noise_t noise_s7;

	assign sx_pos = {5'b0, px} << oct;
	assign sz_pos = {5'b0, pz} << oct;
	assign ix = {24'b0, sx_pos[39:32]};
	assign iz = {24'b0, sz_pos[39:32]};

	assign smx = 50'(ffx_s2) * 50'(18'd196608 - {1'b0, fx_s2, 1'b0});
	assign smz = 50'(ffz_s2) * 50'(18'd196608 - {1'b0, fz_s2, 1'b0});

	assign sx_w = {1'b0, sx_s3};
	assign sz_w = {1'b0, sz_s3};
	assign rx = 17'd65536 - sx_w;
	assign rz = 17'd65536 - sz_w;

	assign acc = 55'(p_s6[0]) + 55'(p_s6[1]) + 55'(p_s6[2]) + 55'(p_s6[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2[0] <= hash_pre(ix, iz, sbase);
			n_s2[1] <= hash_pre(ix + 32'd1, iz, sbase);
			n_s2[2] <= hash_pre(ix, iz + 32'd1, sbase);
			n_s2[3] <= hash_pre(ix + 32'd1, iz + 32'd1, sbase);
			fx_s2 <= sx_pos[31:16];
			fz_s2 <= sz_pos[31:16];
			ffx_s2 <= 32'(sx_pos[31:16]) * 32'(sx_pos[31:16]);
			ffz_s2 <= 32'(sz_pos[31:16]) * 32'(sz_pos[31:16]);
			sx_s3 <= smx[47:32];
			sz_s3 <= smz[47:32];
			w_s4[0] <= 34'(rx) * 34'(rz);
			w_s4[1] <= 34'(sx_w) * 34'(rz);
			w_s4[2] <= 34'(rx) * 34'(sz_w);
			w_s4[3] <= 34'(sx_w) * 34'(sz_w);
			w_s5 <= w_s4;
			for (int c = 0; c < 4; c++) begin
				p_s6[c] <= 53'(v[c]) * $signed(53'(w_s5[c]));
			end
			noise_s7 <= 18'(acc >>> 32);
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_corner
		fvn_hash u_hash (
			.clk(clk),
			.en(en),
			.n(n_s2[c]),
			.v(v[c])
		);
	end

	assign noise = noise_s7;
endmodule
`default_nettype wire

// ===== design/fractal_value_noise_top.sv =====
// Top level of the six-octave fractal value noise height generator.
// The block takes one coordinate pair per clock while not stalled and returns its height
// through an eight-stage pipeline: position multiply, lattice setup, three hash stages,
// blend multiply, blend sum and octave sum. The whole pipeline holds while a finished
// height waits on the result channel, so nothing is lost or repeated under stalls.
`default_nettype none
`include "fractal_value_noise_top_assert.svh"
module fractal_value_noise_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	fvn_sample_if.sink sample,
	fvn_result_if.source result
);
	import fvn_pkg::*;

	logic [31:0] seed_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic en;
	pos_t px_s1, pz_s1;
	logic [31:0] sb_s1 [OCTAVES];
	noise_t noise [OCTAVES];
	logic signed [25:0] total;
	height_t height_s8;

	assign en = !vld_q[PIPE_DEPTH-1] || result.ready;
	assign sample.ready = en;
	assign result.valid = vld_q[PIPE_DEPTH-1];
	assign result.height = height_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (en) begin
				vld_q <= {vld_q[PIPE_DEPTH-2:0], sample.valid};
			end
		end
	end

	always_comb begin
		total = '0;
		for (int o = 0; o < OCTAVES; o++) begin
			total = total + (26'(noise[o]) <<< (OCTAVES - 1 - o));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= pos_t'(clamp_coord(sample.x_coord)) * pos_t'(FREQ_Q32);
			pz_s1 <= pos_t'(clamp_coord(sample.z_coord)) * pos_t'(FREQ_Q32);
			for (int o = 0; o < OCTAVES; o++) begin
				sb_s1[o] <= (seed_q + 32'(o) * OCT_SEED_STEP) * SEED_MUL;
			end
			height_s8 <= 18'((total + 26'sd2097152) >>> 6);
		end
	end

	for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
		fvn_octave u_octave (
			.clk(clk),
			.en(en),
			.oct(3'(o)),
			.px(px_s1),
			.pz(pz_s1),
			.sbase(sb_s1[o]),
			.noise(noise[o])
		);
	end

	`FVN_ASSERT_NEXT(a_accept_enters, clk, arst_n, sample.valid && sample.ready, vld_q[0], "accepted request did not enter the first stage")
	`FVN_ASSERT_NEXT(a_stall_holds, clk, arst_n, result.valid && !result.ready, $stable(vld_q), "pipeline moved during an output stall")
	`FVN_ASSERT_NOW(a_block_only_on_stall, clk, arst_n, !sample.ready, result.valid && !result.ready, "input blocked without an output stall")
endmodule
`default_nettype wire

// ===== sim/fvn_height_checker.sv =====
// Checker that predicts the terrain height of every accepted request and compares the results.
module fvn_height_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	fvn_sample_if sample,
	fvn_result_if result,
	output int fail_count,
	output int heights_pending
);
	import fvn_pkg::*;

	localparam longint FREQ = 64'd21474836;
	localparam longint ONE = 64'd65536;
	localparam int HQ_DEPTH = 64;

	logic [31:0] noise_seed;
	height_t height_mem [HQ_DEPTH];
	logic [5:0] wr_ptr;
	logic [5:0] rd_ptr;
	int pending;
	logic in_acc;
	logic out_acc;

	function automatic longint corner_value(logic [31:0] i, logic [31:0] k, logic [31:0] s);
		logic [31:0] n;
		logic [31:0] h;
		n = i + k * 32'd57 + s * 32'd131;
		n = (n << 13) ^ n;
		h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
		return ONE - longint'(h >> 14);
	endfunction

	function automatic longint smooth(longint f);
		return (f * f * ((64'd3 << 16) - 2 * f)) >>> 32;
	endfunction

	function automatic longint octave_noise(logic [31:0] x, logic [31:0] z, int o,
			logic [31:0] s);
		logic [63:0] px;
		logic [63:0] pz;
		logic [31:0] ix;
		logic [31:0] iz;
		longint sx;
		longint sz;
		longint acc;
		px = 64'(x) * (FREQ << o);
		pz = 64'(z) * (FREQ << o);
		ix = px[63:32];
		iz = pz[63:32];
		sx = smooth(longint'(px[31:16]));
		sz = smooth(longint'(pz[31:16]));
		acc = corner_value(ix, iz, s) * (ONE - sx) * (ONE - sz)
			+ corner_value(ix + 1, iz, s) * sx * (ONE - sz)
			+ corner_value(ix, iz + 1, s) * (ONE - sx) * sz
			+ corner_value(ix + 1, iz + 1, s) * sx * sz;
		return acc >>> 32;
	endfunction

	function automatic height_t terrain_height(coord_t xc, coord_t zc, logic [31:0] sd);
		longint total;
		longint hv;
		total = 0;
		if (xc > COORD_W'(GRID_SIZE - 1)) xc = COORD_W'(GRID_SIZE - 1);
		if (zc > COORD_W'(GRID_SIZE - 1)) zc = COORD_W'(GRID_SIZE - 1);
		for (int o = 0; o < OCTAVES; o++) begin
			total += octave_noise(32'(xc), 32'(zc), o, sd + 32'(o) * 32'd1000) <<< (5 - o);
		end
		hv = (total + (64'sd1 <<< 21)) >>> 6;
		return height_t'(hv);
	endfunction

	assign in_acc = sample.valid && sample.ready;
	assign out_acc = result.valid && result.ready;
	assign heights_pending = pending;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed <= 32'd0;
			fail_count <= 0;
			wr_ptr <= '0;
			rd_ptr <= '0;
			pending <= 0;
		end else begin
			if (in_acc) begin
				height_mem[wr_ptr] <= terrain_height(sample.x_coord, sample.z_coord, noise_seed);
				wr_ptr <= wr_ptr + 6'd1;
			end
			if (out_acc) begin
				if (pending == 0) begin
					$error("height: no request pending, got %0d", result.height);
					fail_count <= fail_count + 1;
				end else begin
					if (height_mem[rd_ptr] !== result.height) begin
						$error("height: expected %0d, actual %0d", height_mem[rd_ptr],
							result.height);
						fail_count <= fail_count + 1;
					end
					rd_ptr <= rd_ptr + 6'd1;
				end
			end
			pending <= pending + (in_acc ? 1 : 0) - ((out_acc && pending != 0) ? 1 : 0);
			if (cfg_we) noise_seed <= cfg_wdata;
		end
	end
endmodule

// ===== sim/fractal_value_noise_top_tb.sv =====
// Testbench top: drives requests, seed writes and result stalls, and gives the verdict.
module fractal_value_noise_top_tb;
	import fvn_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	int fail_count;
	int heights_pending;
	bit long_hold;
	bit hold_done;

	fvn_sample_if sample();
	fvn_result_if result();

	fractal_value_noise_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.sample(sample.sink), .result(result.source)
	);

	fvn_height_checker checker_inst (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.sample(sample), .result(result), .fail_count(fail_count),
		.heights_pending(heights_pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("fractal_value_noise_top verification failed");
		$finish;
	end

	task automatic send_request(coord_t xc, coord_t zc);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.x_coord <= xc;
		sample.z_coord <= zc;
		do @(posedge clk); while (!sample.ready);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (heights_pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] sd);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= sd;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int hold;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				result.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_done = 1;
			end
			hold = $urandom_range(0, 8);
			if ($urandom_range(0, 2) == 0) hold = 0;
			if (hold != 0) begin
				result.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] seeds[6];
		seeds = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h12345678, 32'h0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample.valid = 1'b0;
		sample.x_coord = '0;
		sample.z_coord = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(10'd0, 10'd0);
		send_request(10'd1023, 10'd1023);
		send_request(10'd0, 10'd1023);
		send_request(10'd1023, 10'd0);
		send_request(10'd200, 10'd200);
		send_request(10'h155, 10'h2aa);
		send_request(10'h2aa, 10'h155);
		send_request(10'd1, 10'd1);
		write_seed(32'h7fffffff);
		send_request(10'd0, 10'd0);
		send_request(10'd1023, 10'd1023);
		write_seed(32'h80000000);
		send_request(10'd512, 10'd17);
		send_request(10'd1023, 10'd1023);
		long_hold = 1;
		for (int i = 0; i < 40; i++) send_request(10'($urandom), 10'($urandom));
		for (int p = 0; p < 6; p++) begin
			write_seed(p == 5 ? $urandom : seeds[p]);
			for (int i = 0; i < 65; i++) send_request(10'($urandom), 10'($urandom));
		end
		drain();
		if (fail_count == 0) begin
			$display("fractal_value_noise_top verification clean");
		end else begin
			$display("fractal_value_noise_top verification failed");
		end
		$finish;
	end
endmodule
